// File: sv/rotate_through_carry_unit_macros.svh
// ---------------------------------------------------------------------------
// Rotate-through-carry unit assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ROTATE_THROUGH_CARRY_UNIT_MACROS_SVH
`define ROTATE_THROUGH_CARRY_UNIT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define RTCU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent
`define RTCU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/rtcu_pkg.sv
// ---------------------------------------------------------------------------
// Rotate-through-carry unit package
// Types and codes shared by the datapath and the top level, and a count helper.
// ---------------------------------------------------------------------------
package rtcu_pkg;

   // Rotate direction
   typedef enum logic {
      OP_RCL = 1'b0,
      OP_RCR = 1'b1
   } opcode_type;

   // Operand size
   typedef enum logic [1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_32 = 2'd2,
      WIDTH_64 = 2'd3
   } width_code_type;

   // Ring lengths (operand bits plus the carry)
   localparam logic [6:0] RING_8  = 7'd9;
   localparam logic [6:0] RING_16 = 7'd17;
   localparam logic [6:0] RING_32 = 7'd33;
   localparam logic [6:0] RING_64 = 7'd65;

   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned REQ_USER_W = 3;
   localparam int unsigned RSP_DATA_W = 72;

   typedef struct packed {
      opcode_type     opcode;
      width_code_type width_code;
      logic [63:0]    operand;
      logic [7:0]     count;
      logic           carry_in;
      logic           overflow_in;
   } rtcu_req_type;

   typedef struct packed {
      logic [63:0] rotated;
      logic        carry_out;
      logic        overflow_out;
   } rtcu_rsp_type;

   // Reduce a 5-bit count modulo 9 by two compare-and-subtract steps
   function automatic logic [3:0] mod9_of(input logic [4:0] value);
      logic [4:0] rem;
      rem = value;
      if (rem >= 5'd18) begin
         rem = rem - 5'd18;
      end
      if (rem >= 5'd9) begin
         rem = rem - 5'd9;
      end
      return rem[3:0];
   endfunction

endpackage

// File: sv/rotate_through_carry_unit.sv
// ---------------------------------------------------------------------------
// Rotate-through-carry unit
// x86 RCL/RCR on 8, 16, 32 or 64-bit operands with carry and overflow.
//
//   channel | direction | transaction content
//   req_    | in        | opcode, width_code, operand, count, carry, overflow
//   rsp_    | out       | rotated value, carry, overflow
//
// One transaction is taken every cycle while req_tready is high; a result passes
// through the input register and then the result register after acceptance.
// Reset clears both stage valid flags; payload registers are not reset.
// A stalled result holds in the result register while the input register
// still takes a transaction; req_tready falls only when both are full and
// rsp_tready is low.
// ---------------------------------------------------------------------------
`include "rotate_through_carry_unit_macros.svh"

module rotate_through_carry_unit
   import rtcu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [63:0] operand, [71:64] count, [72] carry_in, [73] overflow_in, [79:74] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] opcode, [2:1] width_code
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [63:0] rotated, [64] carry_out, [65] overflow_out, [71:66] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic         s1_valid_ff;
   logic         s1_valid_in;
   rtcu_req_type s1_req_ff;
   rtcu_req_type req_unpacked;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rtcu_rsp_type rsp_ff;
   rtcu_rsp_type core_rsp;
   logic         advance;
   logic         req_take;

   // Unpack the incoming transaction
   assign req_unpacked.opcode      = opcode_type'(req_tuser[0]);
   assign req_unpacked.width_code  = width_code_type'(req_tuser[2:1]);
   assign req_unpacked.operand     = req_tdata[63:0];
   assign req_unpacked.count       = req_tdata[71:64];
   assign req_unpacked.carry_in    = req_tdata[72];
   assign req_unpacked.overflow_in = req_tdata[73];

   // Advance the result stage when it is empty or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the input payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_unpacked;
      end
   end

   rtcu_core u_core (
      .req (s1_req_ff),
      .rsp (core_rsp)
   );

   // Capture the result payload
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.overflow_out, rsp_ff.carry_out, rsp_ff.rotated};

   // Input stage must hold while the result stage is stalled
   `RTCU_ASSERT_NEXT(a_s1_hold, s1_valid_ff && rsp_valid_ff && !rsp_tready, s1_valid_ff, "input stage lost under stall")

   // 8-bit and 16-bit results never carry bits above the operand width
   `RTCU_ASSERT_NOW(a_w8_clean, s1_valid_ff && s1_req_ff.width_code == WIDTH_8, core_rsp.rotated[63:8] == 56'd0, "8-bit result has high bits")
   `RTCU_ASSERT_NOW(a_w16_clean, s1_valid_ff && s1_req_ff.width_code == WIDTH_16, core_rsp.rotated[63:16] == 48'd0, "16-bit result has high bits")

   // A zero masked count leaves both flags untouched
   `RTCU_ASSERT_NOW(a_zero_pass, s1_valid_ff && s1_req_ff.count[4:0] == 5'd0 && (s1_req_ff.width_code != WIDTH_64 || !s1_req_ff.count[5]), core_rsp.carry_out == s1_req_ff.carry_in && core_rsp.overflow_out == s1_req_ff.overflow_in, "flags changed on zero count")

endmodule

// File: sv/rtcu_core.sv
// ---------------------------------------------------------------------------
// Rotate-through-carry datapath
// Single-pass RCL/RCR of an operand and carry ring, with flag update.
// ---------------------------------------------------------------------------
module rtcu_core
   import rtcu_pkg::*;
(
   input  rtcu_req_type req,
   output rtcu_rsp_type rsp
);

   logic [5:0]  masked;
   logic [5:0]  eff;
   logic [6:0]  ring_len;
   logic [6:0]  shamt;
   logic [17:0] dbl_8;
   logic [33:0] dbl_16;
   logic [65:0] dbl_32;
   logic [129:0] dbl_64;
   logic [17:0] sh_8;
   logic [33:0] sh_16;
   logic [65:0] sh_32;
   logic [129:0] sh_64;
   logic [63:0] rot_val;
   logic        rot_carry;
   logic        msb;
   logic        msb_next;
   logic [63:0] operand_masked;

   // Mask the raw count and reduce it modulo the ring length
   always_comb begin
      masked   = {1'b0, req.count[4:0]};
      eff      = masked;
      ring_len = RING_64;
      case (req.width_code)
         WIDTH_8: begin
            eff      = {2'b00, mod9_of(req.count[4:0])};
            ring_len = RING_8;
         end
         WIDTH_16: begin
            if (masked >= 6'd17) begin
               eff = masked - 6'd17;
            end
            ring_len = RING_16;
         end
         WIDTH_32: begin
            ring_len = RING_32;
         end
         WIDTH_64: begin
            masked   = req.count[5:0];
            eff      = req.count[5:0];
            ring_len = RING_64;
         end
         default: begin
            ring_len = RING_64;
         end
      endcase
   end

   // Express every rotate as a right rotate of the ring
   assign shamt = (req.opcode == OP_RCR) ? {1'b0, eff} : (ring_len - {1'b0, eff});

   // Double each ring so a right shift yields the rotation in the low bits
   assign dbl_8  = {req.carry_in, req.operand[7:0],  req.carry_in, req.operand[7:0]};
   assign dbl_16 = {req.carry_in, req.operand[15:0], req.carry_in, req.operand[15:0]};
   assign dbl_32 = {req.carry_in, req.operand[31:0], req.carry_in, req.operand[31:0]};
   assign dbl_64 = {req.carry_in, req.operand,       req.carry_in, req.operand};

   assign sh_8  = dbl_8  >> shamt;
   assign sh_16 = dbl_16 >> shamt;
   assign sh_32 = dbl_32 >> shamt;
   assign sh_64 = dbl_64 >> shamt;

   // Select the ring for the operand size and pick its sign bits
   always_comb begin
      case (req.width_code)
         WIDTH_8: begin
            rot_val        = {56'd0, sh_8[7:0]};
            rot_carry      = sh_8[8];
            operand_masked = {56'd0, req.operand[7:0]};
            msb            = sh_8[7];
            msb_next       = sh_8[6];
         end
         WIDTH_16: begin
            rot_val        = {48'd0, sh_16[15:0]};
            rot_carry      = sh_16[16];
            operand_masked = {48'd0, req.operand[15:0]};
            msb            = sh_16[15];
            msb_next       = sh_16[14];
         end
         WIDTH_32: begin
            rot_val        = {32'd0, sh_32[31:0]};
            rot_carry      = sh_32[32];
            operand_masked = {32'd0, req.operand[31:0]};
            msb            = sh_32[31];
            msb_next       = sh_32[30];
         end
         default: begin
            rot_val        = sh_64[63:0];
            rot_carry      = sh_64[64];
            operand_masked = req.operand;
            msb            = sh_64[63];
            msb_next       = sh_64[62];
         end
      endcase
   end

   // Pass through on a zero effective count; update overflow on a count of one
   always_comb begin
      rsp.rotated      = operand_masked;
      rsp.carry_out    = req.carry_in;
      rsp.overflow_out = req.overflow_in;
      if (eff != 6'd0) begin
         rsp.rotated   = rot_val;
         rsp.carry_out = rot_carry;
         if (masked == 6'd1) begin
            rsp.overflow_out = (req.opcode == OP_RCR) ? (msb ^ msb_next) : (msb ^ rot_carry);
         end
      end
   end

endmodule
